### design/eabv_pkg.sv
//------------------------------------------------------------------------------
// eabv_pkg
// Types, constants and helpers shared by the Euler angle to basis vector block.
//------------------------------------------------------------------------------
package eabv_pkg;

	localparam int WORK_FRAC = 30;
	localparam int WW = 34;
	localparam logic signed [WW-1:0] ONE_W = 34'sd1073741824;
	localparam logic signed [WW-1:0] INV_GAIN = 34'sd652032874;
	localparam logic [31:0] DEG_TO_RAD = 32'd18740330;
	localparam int ATAN_N = 32;

	typedef logic signed [WW-1:0] work_t;

	typedef struct packed {
		logic signed [15:0] yaw_deg;
		logic signed [15:0] pitch_deg;
		logic signed [15:0] roll_deg;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] fwd_x;
		logic signed [15:0] fwd_y;
		logic signed [15:0] fwd_z;
		logic signed [15:0] rgt_x;
		logic signed [15:0] rgt_y;
		logic signed [15:0] rgt_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} out_item_t;

	// One CORDIC lane: rotation state plus the fold flags of its angle.
	typedef struct packed {
		work_t x;
		work_t y;
		work_t z;
		logic  neg;
		logic  back;
	} lane_t;

	typedef struct packed {
		lane_t yaw;
		lane_t pitch;
		lane_t roll;
	} triple_t;

	function automatic work_t atan_w(input int i);
		logic [31:0] t [ATAN_N];
		t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
			32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
			32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
			32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
			32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
			32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
			32'h00000001, 32'h00000000};
		return work_t'({2'b00, t[i % ATAN_N]});
	endfunction

	function automatic work_t clampw(input work_t v);
		if (v > ONE_W) begin
			return ONE_W;
		end else if (v < -ONE_W) begin
			return -ONE_W;
		end
		return v;
	endfunction

endpackage

### design/eabv_cell.sv
//------------------------------------------------------------------------------
// eabv_cell
// One CORDIC micro-rotation for all three angles, registered.
//------------------------------------------------------------------------------
module eabv_cell #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  eabv_pkg::triple_t d,
	output logic             vld_s1,
	output eabv_pkg::triple_t q_s1
);
	import eabv_pkg::*;

	function automatic lane_t rot(input lane_t a);
		lane_t r;
		work_t dx;
		work_t dy;
		r = a;
		dx = a.y >>> STEP;
		dy = a.x >>> STEP;
		if (!a.z[WW-1]) begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - atan_w(STEP);
		end else begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + atan_w(STEP);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1.yaw   <= rot(d.yaw);
			q_s1.pitch <= rot(d.pitch);
			q_s1.roll  <= rot(d.roll);
		end
	end

endmodule

### design/eabv_front.sv
//------------------------------------------------------------------------------
// eabv_front
// Wraps and folds the three angles and scales them to radians.
//------------------------------------------------------------------------------
module eabv_front #(
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  eabv_pkg::in_item_t d,
	output logic              vld_s2,
	output eabv_pkg::triple_t q_s2
);
	import eabv_pkg::*;

	localparam int AW = ANGLE_FRAC_BITS + 10;
	localparam logic signed [AW:0] FULL = (AW+1)'(360 << ANGLE_FRAC_BITS);
	localparam logic signed [AW:0] HALF = (AW+1)'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [AW:0] QUAR = (AW+1)'(90 << ANGLE_FRAC_BITS);
	localparam logic [AW+33:0] RND = ANGLE_FRAC_BITS > 0 ?
		(AW+34)'(1) << (ANGLE_FRAC_BITS > 0 ? ANGLE_FRAC_BITS - 1 : 0) : '0;

	// A negative angle is lifted by whole turns, then reduced by shifted turns.
	localparam int TURNS = (32768 + (360 << ANGLE_FRAC_BITS) - 1) / (360 << ANGLE_FRAC_BITS);
	localparam int NSUB = $clog2(TURNS);
	localparam logic signed [AW+16:0] FULL_W = (AW+17)'(360 << ANGLE_FRAC_BITS);
	localparam logic signed [AW+16:0] LIFT = (AW+17)'(TURNS * (360 << ANGLE_FRAC_BITS));

	typedef struct packed {
		logic [AW-1:0] m;
		logic          neg;
		logic          back;
	} fold_t;

	function automatic fold_t fold(input logic signed [15:0] raw);
		fold_t f;
		logic signed [AW+16:0] w;
		logic signed [AW:0] m;
		w = (AW+17)'(raw);
		if (w < 0) begin
			w = w + LIFT;
		end
		for (int k = NSUB - 1; k >= 0; k--) begin
			if (w >= (FULL_W <<< k)) begin
				w = w - (FULL_W <<< k);
			end
		end
		m = (AW+1)'(w);
		if (m < 0) begin
			m = m + FULL;
		end
		if (m >= HALF) begin
			m = m - FULL;
		end
		f.neg = m < 0;
		if (f.neg) begin
			m = -m;
		end
		f.back = m > QUAR;
		if (f.back) begin
			m = HALF - m;
		end
		f.m = AW'(m);
		return f;
	endfunction

	function automatic lane_t scale(input fold_t f);
		lane_t l;
		logic [AW+33:0] p;
		p = (AW+34)'(f.m) * (AW+34)'(DEG_TO_RAD);
		p = (p + RND) >> ANGLE_FRAC_BITS;
		l.x = INV_GAIN;
		l.y = '0;
		l.z = WW'(p);
		l.neg = f.neg;
		l.back = f.back;
		return l;
	endfunction

	fold_t fy_s1, fp_s1, fr_s1;
	logic  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fy_s1 <= fold(d.yaw_deg);
			fp_s1 <= fold(d.pitch_deg);
			fr_s1 <= fold(d.roll_deg);
			q_s2.yaw <= scale(fy_s1);
			q_s2.pitch <= scale(fp_s1);
			q_s2.roll <= scale(fr_s1);
		end
	end

endmodule

### design/eabv_combine.sv
//------------------------------------------------------------------------------
// eabv_combine
// Forms the nine basis vector components from the sines and cosines.
//------------------------------------------------------------------------------
module eabv_combine #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  eabv_pkg::triple_t  d,
	output logic               vld_s4,
	output eabv_pkg::out_item_t q_s4
);
	import eabv_pkg::*;

	localparam int SH = WORK_FRAC - OUT_FRAC_BITS;
	localparam logic signed [WW+1:0] LIM = (WW+2)'(1) <<< OUT_FRAC_BITS;

	function automatic work_t mulw(input work_t a, input work_t b);
		logic signed [2*WW-1:0] p;
		p = (2*WW)'(a) * (2*WW)'(b) + ((2*WW)'(1) <<< (WORK_FRAC - 1));
		return WW'(p >>> WORK_FRAC);
	endfunction

	function automatic logic [15:0] to_out(input logic signed [WW+1:0] v);
		logic signed [WW+1:0] r;
		r = v;
		if (SH > 0) begin
			r = (v + ((WW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
		end
		if (r > LIM) begin
			r = LIM;
		end else if (r < -LIM) begin
			r = -LIM;
		end
		return r[15:0];
	endfunction

	work_t sy, cy, sp, cp, sr, cr;

	always_comb begin
		sy = clampw(d.yaw.y);
		cy = clampw(d.yaw.x);
		sp = clampw(d.pitch.y);
		cp = clampw(d.pitch.x);
		sr = clampw(d.roll.y);
		cr = clampw(d.roll.x);
		if (d.yaw.neg) sy = -sy;
		if (d.yaw.back) cy = -cy;
		if (d.pitch.neg) sp = -sp;
		if (d.pitch.back) cp = -cp;
		if (d.roll.neg) sr = -sr;
		if (d.roll.back) cr = -cr;
	end

	work_t sy_s1, cy_s1, sp_s1, cp_s1, sr_s1, cr_s1;
	work_t srsp_s2, crsp_s2, cpcy_s2, cpsy_s2, nsp_s2, srcp_s2, crcp_s2;
	work_t crsy_s2, crcy_s2, srsy_s2, srcy_s2, sy_s2, cy_s2;
	work_t a_s3, b_s3, c_s3, e_s3, f_s3, g_s3, h_s3, k_s3, m_s3;
	work_t crsy_s3, crcy_s3, srsy_s3, srcy_s3;
	logic  v_s1, v_s2, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vld_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sy_s1 <= sy;
			cy_s1 <= cy;
			sp_s1 <= sp;
			cp_s1 <= cp;
			sr_s1 <= sr;
			cr_s1 <= cr;
			srsp_s2 <= mulw(sr_s1, sp_s1);
			crsp_s2 <= mulw(cr_s1, sp_s1);
			cpcy_s2 <= mulw(cp_s1, cy_s1);
			cpsy_s2 <= mulw(cp_s1, sy_s1);
			nsp_s2 <= -sp_s1;
			srcp_s2 <= mulw(sr_s1, cp_s1);
			crcp_s2 <= mulw(cr_s1, cp_s1);
			crsy_s2 <= mulw(cr_s1, sy_s1);
			crcy_s2 <= mulw(cr_s1, cy_s1);
			srsy_s2 <= mulw(sr_s1, sy_s1);
			srcy_s2 <= mulw(sr_s1, cy_s1);
			sy_s2 <= sy_s1;
			cy_s2 <= cy_s1;
			a_s3 <= cpcy_s2;
			b_s3 <= cpsy_s2;
			c_s3 <= nsp_s2;
			e_s3 <= mulw(srsp_s2, cy_s2);
			f_s3 <= mulw(srsp_s2, sy_s2);
			g_s3 <= mulw(crsp_s2, cy_s2);
			h_s3 <= mulw(crsp_s2, sy_s2);
			k_s3 <= srcp_s2;
			m_s3 <= crcp_s2;
			q_s4.fwd_x <= to_out((WW+2)'(a_s3));
			q_s4.fwd_y <= to_out((WW+2)'(b_s3));
			q_s4.fwd_z <= to_out((WW+2)'(c_s3));
			q_s4.rgt_x <= to_out((WW+2)'(crsy_s3) - (WW+2)'(e_s3));
			q_s4.rgt_y <= to_out(-(WW+2)'(f_s3) - (WW+2)'(crcy_s3));
			q_s4.rgt_z <= to_out(-(WW+2)'(k_s3));
			q_s4.up_x <= to_out((WW+2)'(g_s3) + (WW+2)'(srsy_s3));
			q_s4.up_y <= to_out((WW+2)'(h_s3) - (WW+2)'(srcy_s3));
			q_s4.up_z <= to_out((WW+2)'(m_s3));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crsy_s3 <= crsy_s2;
			crcy_s3 <= crcy_s2;
			srsy_s3 <= srsy_s2;
			srcy_s3 <= srcy_s2;
		end
	end

endmodule

### design/euler_angles_to_basis_vectors.sv
//------------------------------------------------------------------------------
// euler_angles_to_basis_vectors
// Pipelined conversion of yaw, pitch and roll to forward, right and up vectors.
//------------------------------------------------------------------------------
// Channel  Signals                    Payload
// in       in_valid / in_ready        in_item_t  (yaw, pitch, roll, Q10.6 deg)
// out      out_valid / out_ready      out_item_t (nine components, Q2.14)
//
// One transfer per cycle is accepted while the output is not stalled; each item passes
// through the front stages, the chain of CORDIC cells and then the product tree.
// The whole pipeline advances when the output register is empty or being read,
// so a stalled output holds every stage in place.
// Reset clears only the valid bits.
//------------------------------------------------------------------------------
module euler_angles_to_basis_vectors #(
	parameter int OUT_FRAC_BITS = 14,
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int SINCOS_ITERATIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  eabv_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output eabv_pkg::out_item_t out_data
);
	import eabv_pkg::*;

	localparam int N = SINCOS_ITERATIONS > 32 ? 32 : SINCOS_ITERATIONS;

	logic    en;
	logic    vld [N+1];
	triple_t tr [N+1];

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	eabv_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(in_valid), .d(in_data),
		.vld_s2(vld[0]), .q_s2(tr[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		eabv_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld[i]), .d(tr[i]),
			.vld_s1(vld[i+1]), .q_s1(tr[i+1])
		);
	end

	eabv_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld[N]), .d(tr[N]),
		.vld_s4(out_valid), .q_s4(out_data)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready does not follow output stage");
	a_zlim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.up_z <= 16'sd16384 && out_data.up_z >= -16'sd16384)
		else $error("component out of range");

endmodule
